>>> sv/pmcq_pkg.sv
// ----------------------------------------------------------------------------
// Partitioned multi-class queue package
// Codes, stream field layout and the command and status types that the
// controller and datapath exchange.
// ----------------------------------------------------------------------------
package pmcq_pkg;

    localparam int MAX_CLASSES = 3;
    localparam int CLASS_W     = 2;
    localparam int WORD_W      = 32;
    localparam int FILL_W      = 4;
    localparam int TOTAL_W     = 5;

    localparam int S_TDATA_W = 2 * WORD_W;
    localparam int S_TUSER_W = 2 + CLASS_W;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_PEEK  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDEF = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
    } pmcq_cmd_t;

    typedef struct packed {
        logic out_free;
    } pmcq_stat_t;

endpackage

>>> sv/partitioned_multi_class_queue_unit.sv
// Each accepted item passes capture, update plus store access, then result
// load into the output register on the m_ side. Items are taken one at a
// time: no new item is accepted before the previous result load.
// A stalled result holds back the next item only at its result load.
// Reset puts every class pointer at its region base and zeroes all counts;
// entry store contents are undefined until written.
// ----------------------------------------------------------------------------
// Partitioned multi-class queue unit
// Shared entry store split into one circular queue region per message class.
// ----------------------------------------------------------------------------
module partitioned_multi_class_queue_unit
    import pmcq_pkg::*;
#(
    parameter int NUM_CLASSES  = 3,
    parameter int CLASS0_DEPTH = 4,
    parameter int CLASS1_DEPTH = 4,
    parameter int CLASS2_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // handle[31:0], byte_count[63:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode[1:0], class_id[3:2]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // handle_out[31:0], byte_count_out[63:32], class_fill[67:64],
    // total_fill[72:68], zero padding[79:73]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [M_TUSER_W-1:0] m_tuser
);

    pmcq_cmd_t  cmd;
    pmcq_stat_t stat;

    pmcq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pmcq_dp #(
        .NUM_CLASSES  (NUM_CLASSES),
        .CLASS0_DEPTH (CLASS0_DEPTH),
        .CLASS1_DEPTH (CLASS1_DEPTH),
        .CLASS2_DEPTH (CLASS2_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in flight");

    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.execute, cmd.load_out}))
        else $error("controller issued overlapping commands");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

    a_exec_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.execute)
        else $error("accepted item was not executed");
`endif

endmodule

>>> sv/pmcq_ctrl.sv
// ----------------------------------------------------------------------------
// Partitioned multi-class queue controller
// Sequences one item through capture, execute and result load.
// ----------------------------------------------------------------------------
module pmcq_ctrl
    import pmcq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  pmcq_stat_t stat,
    output pmcq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    state_t state_reg;
    logic   ready_reg;
    logic   exec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            exec_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EXEC;
                        ready_reg <= 1'b0;
                        exec_reg  <= 1'b1;
                    end
                end
                ST_EXEC: begin
                    exec_reg  <= 1'b0;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (stat.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                    exec_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready     = ready_reg;
    assign cmd.capture  = s_tvalid && ready_reg;
    assign cmd.execute  = exec_reg;
    assign cmd.load_out = (state_reg == ST_LOAD) && stat.out_free;

endmodule

>>> sv/pmcq_dp.sv
// ----------------------------------------------------------------------------
// Partitioned multi-class queue datapath
// Per-class pointers and counts, the shared entry store and the result register.
// ----------------------------------------------------------------------------
module pmcq_dp
    import pmcq_pkg::*;
#(
    parameter int NUM_CLASSES  = 3,
    parameter int CLASS0_DEPTH = 4,
    parameter int CLASS1_DEPTH = 4,
    parameter int CLASS2_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pmcq_cmd_t            cmd,
    output pmcq_stat_t           stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int STORE_DEPTH = CLASS0_DEPTH + CLASS1_DEPTH + CLASS2_DEPTH;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int MAXD01      = (CLASS0_DEPTH > CLASS1_DEPTH) ? CLASS0_DEPTH : CLASS1_DEPTH;
    localparam int MAXD        = (MAXD01 > CLASS2_DEPTH) ? MAXD01 : CLASS2_DEPTH;
    localparam int CW          = $clog2(MAXD + 1);
    localparam int TW          = $clog2(STORE_DEPTH + 1);
    localparam int NUM_DEF     = (NUM_CLASSES < MAX_CLASSES) ? NUM_CLASSES : MAX_CLASSES;
    localparam int ENTRY_W     = 2 * WORD_W;

    function automatic logic [AW-1:0] base_of(input logic [CLASS_W-1:0] c);
        case (c)
            CLASS_W'(0): base_of = '0;
            CLASS_W'(1): base_of = AW'(CLASS0_DEPTH);
            default:     base_of = AW'(CLASS0_DEPTH + CLASS1_DEPTH);
        endcase
    endfunction

    function automatic logic [AW-1:0] last_of(input logic [CLASS_W-1:0] c);
        case (c)
            CLASS_W'(0): last_of = AW'(CLASS0_DEPTH - 1);
            CLASS_W'(1): last_of = AW'(CLASS0_DEPTH + CLASS1_DEPTH - 1);
            default:     last_of = AW'(STORE_DEPTH - 1);
        endcase
    endfunction

    function automatic logic [CW-1:0] depth_of(input logic [CLASS_W-1:0] c);
        case (c)
            CLASS_W'(0): depth_of = CW'(CLASS0_DEPTH);
            CLASS_W'(1): depth_of = CW'(CLASS1_DEPTH);
            default:     depth_of = CW'(CLASS2_DEPTH);
        endcase
    endfunction

    mode_t              mode_reg;
    logic [CLASS_W-1:0] cls_reg;
    logic [WORD_W-1:0]  handle_reg;
    logic [WORD_W-1:0]  bytes_reg;

    logic [AW-1:0] head_reg [MAX_CLASSES];
    logic [AW-1:0] head_next [MAX_CLASSES];
    logic [AW-1:0] tail_reg [MAX_CLASSES];
    logic [AW-1:0] tail_next [MAX_CLASSES];
    logic [CW-1:0] cnt_reg [MAX_CLASSES];
    logic [CW-1:0] cnt_next [MAX_CLASSES];
    logic [TW-1:0] total_reg;
    logic [TW-1:0] total_next;

    logic [ENTRY_W-1:0] store [STORE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    status_t       res_status_reg;
    status_t       res_status_next;
    logic [CW-1:0] res_fill_reg;
    logic [CW-1:0] res_fill_next;
    logic [TW-1:0] res_total_reg;
    logic          pop_ok_reg;
    logic          pop_ok_next;
    logic          wr_en;

    logic               cls_def;
    logic [CLASS_W-1:0] cidx;
    logic [CW-1:0]      cnt_cur;
    logic [AW-1:0]      head_cur;
    logic [AW-1:0]      tail_cur;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    status_t              out_status_reg;

    assign cls_def  = (cls_reg < CLASS_W'(NUM_DEF));
    assign cidx     = cls_def ? cls_reg : '0;
    assign cnt_cur  = cnt_reg[cidx];
    assign head_cur = head_reg[cidx];
    assign tail_cur = tail_reg[cidx];

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        total_next      = total_reg;
        res_status_next = STAT_OK;
        res_fill_next   = '0;
        pop_ok_next     = 1'b0;
        wr_en           = 1'b0;
        case (mode_reg)
            MODE_CLEAR: begin
                for (int c = 0; c < MAX_CLASSES; c++) begin
                    head_next[c] = base_of(CLASS_W'(c));
                    tail_next[c] = base_of(CLASS_W'(c));
                    cnt_next[c]  = '0;
                end
                total_next = '0;
            end
            MODE_PUSH: begin
                if (!cls_def) begin
                    res_status_next = STAT_UNDEF;
                end else if (cnt_cur >= depth_of(cidx)) begin
                    res_status_next = STAT_FULL;
                    res_fill_next   = cnt_cur;
                end else begin
                    wr_en           = 1'b1;
                    head_next[cidx] = (head_cur == last_of(cidx)) ? base_of(cidx)
                                                                  : head_cur + AW'(1);
                    cnt_next[cidx]  = cnt_cur + CW'(1);
                    total_next      = total_reg + TW'(1);
                    res_fill_next   = cnt_cur + CW'(1);
                end
            end
            MODE_POP: begin
                if (!cls_def) begin
                    res_status_next = STAT_UNDEF;
                end else if (cnt_cur == '0) begin
                    res_status_next = STAT_EMPTY;
                end else begin
                    pop_ok_next     = 1'b1;
                    tail_next[cidx] = (tail_cur == last_of(cidx)) ? base_of(cidx)
                                                                  : tail_cur + AW'(1);
                    cnt_next[cidx]  = cnt_cur - CW'(1);
                    total_next      = total_reg - TW'(1);
                    res_fill_next   = cnt_cur - CW'(1);
                end
            end
            default: begin
                res_fill_next = cls_def ? cnt_cur : '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= mode_t'(s_tuser[1:0]);
            cls_reg    <= s_tuser[3:2];
            handle_reg <= s_tdata[WORD_W-1:0];
            bytes_reg  <= s_tdata[2*WORD_W-1:WORD_W];
        end
        if (cmd.execute) begin
            res_status_reg <= res_status_next;
            res_fill_reg   <= res_fill_next;
            res_total_reg  <= total_next;
            pop_ok_reg     <= pop_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < MAX_CLASSES; c++) begin
                head_reg[c] <= base_of(CLASS_W'(c));
                tail_reg[c] <= base_of(CLASS_W'(c));
                cnt_reg[c]  <= '0;
            end
            total_reg <= '0;
        end else if (cmd.execute) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute && wr_en) begin
            store[head_cur] <= {bytes_reg, handle_reg};
        end
        if (cmd.execute && pop_ok_next) begin
            rd_data_reg <= store[tail_cur];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= {M_TDATA_W'(TOTAL_W'(res_total_reg)) << (ENTRY_W + FILL_W)}
                            | {M_TDATA_W'(FILL_W'(res_fill_reg)) << ENTRY_W}
                            | M_TDATA_W'(pop_ok_reg ? rd_data_reg : '0);
        end
    end

    assign stat.out_free  = !out_valid_reg || m_tready;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;
    assign m_tuser        = out_status_reg;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Partitioned multi-class queue unit testbench
// Drives push, pop, clear and peek requests on the s_ stream and predicts
// every result from a private copy of the class regions, pointers and counts.
// Each result on the m_ stream is checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import pmcq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CLASSES  = 3;
    localparam int CLASS0_DEPTH = 4;
    localparam int CLASS1_DEPTH = 4;
    localparam int CLASS2_DEPTH = 8;
    localparam int STORE_DEPTH  = CLASS0_DEPTH + CLASS1_DEPTH + CLASS2_DEPTH;

    localparam logic [CLASS_W-1:0] UNDEF_CLASS = 2'd3;
    localparam int RANDOM_OPS  = 800;
    localparam int CALM_FIRST  = 300;
    localparam int CALM_LAST   = 450;

    typedef struct packed {
        mode_t               mode;
        logic [CLASS_W-1:0]  class_id;
        logic [WORD_W-1:0]   handle;
        logic [WORD_W-1:0]   byte_count;
    } queue_op_t;

    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   handle_out;
        logic [WORD_W-1:0]   byte_count_out;
        logic [FILL_W-1:0]   class_fill;
        logic [TOTAL_W-1:0]  total_fill;
    } queue_reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    queue_op_t    pending_ops[$];
    queue_reply_t replies_due[$];
    queue_op_t    op_on_bus;
    int           ops_sent = 0;
    int           replies_seen = 0;
    int           mismatches = 0;

    logic [WORD_W-1:0]  slot_handle [STORE_DEPTH];
    logic [WORD_W-1:0]  slot_length [STORE_DEPTH];
    int                 head_ptr [NUM_CLASSES];
    int                 tail_ptr [NUM_CLASSES];
    logic [FILL_W-1:0]  class_level [NUM_CLASSES];
    logic [TOTAL_W-1:0] stored_total;

    partitioned_multi_class_queue_unit #(
        .NUM_CLASSES (NUM_CLASSES),
        .CLASS0_DEPTH(CLASS0_DEPTH),
        .CLASS1_DEPTH(CLASS1_DEPTH),
        .CLASS2_DEPTH(CLASS2_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    function automatic int region_base(int c);
        if (c == 0) return 0;
        if (c == 1) return CLASS0_DEPTH;
        return CLASS0_DEPTH + CLASS1_DEPTH;
    endfunction

    function automatic int region_size(int c);
        if (c == 0) return CLASS0_DEPTH;
        if (c == 1) return CLASS1_DEPTH;
        return CLASS2_DEPTH;
    endfunction

    function automatic int next_slot(int c, int p);
        if (p + 1 >= region_base(c) + region_size(c)) return region_base(c);
        return p + 1;
    endfunction

    function automatic void reset_regions();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ptr[c] = region_base(c);
            tail_ptr[c] = region_base(c);
            class_level[c] = '0;
        end
        stored_total = '0;
    endfunction

    function automatic queue_reply_t apply_queue_op(queue_op_t op);
        queue_reply_t r;
        int           c;
        logic         known;
        r = '0;
        r.status = STAT_OK;
        c = op.class_id;
        known = (c < NUM_CLASSES);
        case (op.mode)
            MODE_CLEAR: begin
                reset_regions();
            end
            MODE_PEEK: begin
                if (known) r.class_fill = class_level[c];
            end
            default: begin
                if (!known) begin
                    r.status = STAT_UNDEF;
                end else if (op.mode == MODE_PUSH) begin
                    if (class_level[c] >= region_size(c)) begin
                        r.status = STAT_FULL;
                    end else begin
                        slot_handle[head_ptr[c]] = op.handle;
                        slot_length[head_ptr[c]] = op.byte_count;
                        head_ptr[c] = next_slot(c, head_ptr[c]);
                        class_level[c] = class_level[c] + 1'b1;
                        stored_total = stored_total + 1'b1;
                    end
                    r.class_fill = class_level[c];
                end else begin
                    if (class_level[c] == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.handle_out = slot_handle[tail_ptr[c]];
                        r.byte_count_out = slot_length[tail_ptr[c]];
                        tail_ptr[c] = next_slot(c, tail_ptr[c]);
                        class_level[c] = class_level[c] - 1'b1;
                        stored_total = stored_total - 1'b1;
                    end
                    r.class_fill = class_level[c];
                end
            end
        endcase
        r.total_fill = stored_total;
        return r;
    endfunction

    function automatic logic idle_now(int n);
        if (n >= CALM_FIRST && n < CALM_LAST) return 1'b0;
        return ($urandom_range(99) < 14);
    endfunction

    task automatic add_op(mode_t m, logic [CLASS_W-1:0] c, logic [WORD_W-1:0] h,
                          logic [WORD_W-1:0] b);
        queue_op_t op;
        op.mode = m;
        op.class_id = c;
        op.handle = h;
        op.byte_count = b;
        pending_ops.push_back(op);
    endtask

    task automatic report_bad(string field, logic [WORD_W-1:0] want,
                              logic [WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Result %0d: %s expected %h, got %h", replies_seen, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : drive_ops
        queue_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                replies_due.push_back(apply_queue_op(op_on_bus));
                ops_sent++;
            end
            if (pending_ops.size() != 0 && !idle_now(ops_sent)) begin
                op = pending_ops.pop_front();
                op_on_bus <= op;
                s_tdata <= {op.byte_count, op.handle};
                s_tuser <= {op.class_id, op.mode};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : check_replies
        queue_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result %0d arrived with none outstanding: tuser %h tdata %h",
                                 replies_seen, m_tuser, m_tdata);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (m_tuser != want.status)
                        report_bad("status", WORD_W'(want.status), WORD_W'(m_tuser));
                    if (m_tdata[31:0] != want.handle_out)
                        report_bad("handle_out", want.handle_out, m_tdata[31:0]);
                    if (m_tdata[63:32] != want.byte_count_out)
                        report_bad("byte_count_out", want.byte_count_out, m_tdata[63:32]);
                    if (m_tdata[67:64] != want.class_fill)
                        report_bad("class_fill", WORD_W'(want.class_fill),
                                   WORD_W'(m_tdata[67:64]));
                    if (m_tdata[72:68] != want.total_fill)
                        report_bad("total_fill", WORD_W'(want.total_fill),
                                   WORD_W'(m_tdata[72:68]));
                end
                replies_seen++;
            end
            m_tready <= !idle_now(replies_seen);
        end
    end

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : run_test
        int   r;
        int   push_share;
        int   op_total;
        logic [CLASS_W-1:0] c;
        reset_regions();

        // Fill class 0 past its depth, then drain and underflow class 1.
        for (int i = 0; i < 5; i++) add_op(MODE_PUSH, 2'd0, $urandom, $urandom);
        add_op(MODE_POP, 2'd0, '0, '0);
        add_op(MODE_PUSH, 2'd1, 32'hFFFF_FFFF, 32'h0000_0000);
        add_op(MODE_PUSH, 2'd1, 32'h0000_0000, 32'hFFFF_FFFF);
        add_op(MODE_POP, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(MODE_POP, 2'd1, '0, '0);
        add_op(MODE_POP, 2'd1, '0, '0);
        add_op(MODE_PUSH, UNDEF_CLASS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(MODE_POP, UNDEF_CLASS, '0, '0);
        add_op(MODE_PEEK, 2'd0, '0, '0);
        add_op(MODE_PEEK, UNDEF_CLASS, '0, '0);
        add_op(MODE_PUSH, 2'd2, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        add_op(MODE_PUSH, 2'd2, $urandom, $urandom);
        add_op(MODE_CLEAR, UNDEF_CLASS, $urandom, $urandom);
        add_op(MODE_POP, 2'd2, '0, '0);
        add_op(MODE_PEEK, 2'd2, '0, '0);
        add_op(MODE_PUSH, 2'd0, 32'h1234_5678, 32'h8765_4321);
        add_op(MODE_POP, 2'd0, '0, '0);
        add_op(MODE_CLEAR, 2'd1, '0, '0);

        // Alternate filling and draining phases so that every class hits
        // both its full and its empty boundary and its pointers wrap.
        for (int i = 0; i < RANDOM_OPS; i++) begin
            push_share = ((i / 40) % 2 == 0) ? 65 : 30;
            c = ($urandom_range(15) == 0) ? UNDEF_CLASS : 2'($urandom_range(2));
            r = $urandom_range(99);
            if (r < 2) add_op(MODE_CLEAR, 2'($urandom_range(3)), $urandom, $urandom);
            else if (r < 7) add_op(MODE_PEEK, c, $urandom, $urandom);
            else if (r < 7 + push_share) add_op(MODE_PUSH, c, $urandom, $urandom);
            else add_op(MODE_POP, c, $urandom, $urandom);
        end
        op_total = pending_ops.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (replies_seen < op_total) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && replies_due.size() == 0 && replies_seen == op_total) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
sv/pmcq_pkg.sv
sv/pmcq_ctrl.sv
sv/pmcq_dp.sv
sv/partitioned_multi_class_queue_unit.sv
sim/testbench.sv
